// ===== sv/iec_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and constants for the ICMP echo checker.
// No dependencies; every other file imports this package.
package iec_pkg;

  // Parameter defaults
  localparam int QUEUE_DEPTH_DEF = 8;
  localparam int LENGTH_BITS_DEF = 16;

  // Depth of the command queue between the front and back ends
  localparam int CMD_FIFO_DEPTH = 2;

  // Reset value of the minimum message length register
  localparam logic [7:0] MIN_HEADER_RESET = 8'd8;

  // Type/code words and message layout
  localparam logic [15:0] TC_ECHO_REQUEST = 16'h0800;
  localparam logic [15:0] TC_ECHO_REPLY   = 16'h0000;
  localparam logic [15:0] SUM_GOOD        = 16'hffff;
  localparam int          REC_BYTES       = 4 + 4 + 4;
  localparam int          OFS_TYPE_CODE   = 0;
  localparam int          OFS_CHECKSUM    = 2;
  localparam int          OFS_SEQ_HI      = 4;
  localparam int          OFS_SEQ_LO      = 6;
  localparam int          OFS_TICKS_HI    = 8;
  localparam int          OFS_TICKS_LO    = 10;

  // Input modes
  localparam logic [1:0] MODE_WORD  = 2'd0;
  localparam logic [1:0] MODE_POP   = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;
  localparam logic [1:0] MODE_NOP   = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_IGNORED    = 3'd0;
  localparam logic [2:0] ST_REPLY      = 3'd1;
  localparam logic [2:0] ST_RECORDED   = 3'd2;
  localparam logic [2:0] ST_FULL_DROP  = 3'd3;
  localparam logic [2:0] ST_RECORD_OUT = 3'd4;
  localparam logic [2:0] ST_EMPTY      = 3'd5;
  localparam logic [2:0] ST_CLEARED    = 3'd6;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] data_word;
    logic        odd_tail;
    logic        last_word;
    logic [31:0] src_addr;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] reply_checksum;
    logic [31:0] rec_src;
    logic [31:0] rec_seq;
    logic [31:0] rec_ticks;
  } out_item_t;

  typedef struct packed {
    logic [31:0] src;
    logic [31:0] seq;
    logic [31:0] ticks;
  } rec_t;

  // Work handed from the front end to the back end
  typedef enum logic [1:0] {
    OP_REPORT,
    OP_PUSH,
    OP_POP,
    OP_CLEAR
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t     op;
    logic [2:0]  status;
    logic [15:0] checksum;
    rec_t        rec;
  } cmd_t;

endpackage

// ===== sv/iec_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts input words, keeps the per-message state and
// classifies each finished message into a command. Depends on iec_pkg.
module iec_front #(
  parameter int LENGTH_BITS = iec_pkg::LENGTH_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  iec_pkg::in_item_t in_data,
  input  logic [7:0]       min_header_bytes,
  output logic             cmd_valid,
  input  logic             cmd_ready,
  output iec_pkg::cmd_t    cmd_data
);
  import iec_pkg::*;

  logic [15:0]            running_sum;
  logic [LENGTH_BITS-1:0] byte_count;
  logic [15:0]            type_code_word;
  logic [15:0]            stored_checksum;
  logic [31:0]            seq_field;
  logic [31:0]            tick_field;

  logic [15:0]            running_sum_next;
  logic [LENGTH_BITS-1:0] byte_count_next;
  logic [15:0]            type_code_word_next;
  logic [15:0]            stored_checksum_next;
  logic [31:0]            seq_field_next;
  logic [31:0]            tick_field_next;

  logic                   odd_last;
  logic [15:0]            word;
  logic [16:0]            sum_raw;
  logic [LENGTH_BITS:0]   cnt_raw;
  logic [16:0]            ck_raw;
  logic [15:0]            ck_fold;
  logic                   msg_bad;
  logic                   accept;
  logic                   msg_word;

  assign in_ready = cmd_ready;
  assign accept   = in_valid && in_ready;
  assign msg_word = (in_data.mode == MODE_WORD);

  // A command goes out for every non-word mode and for each final word
  assign cmd_valid = in_valid && (!msg_word || in_data.last_word);

  always_comb begin
    odd_last = in_data.last_word && in_data.odd_tail;
    word     = odd_last ? {in_data.data_word[15:8], 8'h00} : in_data.data_word;

    // Ones-complement add with end-around carry
    sum_raw          = {1'b0, running_sum} + {1'b0, word};
    running_sum_next = sum_raw[15:0] + {15'd0, sum_raw[16]};

    // Byte count, saturating at all ones
    cnt_raw = {1'b0, byte_count} + (odd_last ? (LENGTH_BITS+1)'(1) : (LENGTH_BITS+1)'(2));
    byte_count_next = cnt_raw[LENGTH_BITS] ? '1 : cnt_raw[LENGTH_BITS-1:0];

    type_code_word_next  = type_code_word;
    stored_checksum_next = stored_checksum;
    seq_field_next       = seq_field;
    tick_field_next      = tick_field;
    if (byte_count == LENGTH_BITS'(OFS_TYPE_CODE)) begin
      type_code_word_next = word;
    end else if (byte_count == LENGTH_BITS'(OFS_CHECKSUM)) begin
      stored_checksum_next = word;
    end else if (byte_count == LENGTH_BITS'(OFS_SEQ_HI)) begin
      seq_field_next = {word, seq_field[15:0]};
    end else if (byte_count == LENGTH_BITS'(OFS_SEQ_LO)) begin
      seq_field_next = {seq_field[31:16], word};
    end else if (byte_count == LENGTH_BITS'(OFS_TICKS_HI)) begin
      tick_field_next = {word, tick_field[15:0]};
    end else if (byte_count == LENGTH_BITS'(OFS_TICKS_LO)) begin
      tick_field_next = {tick_field[31:16], word};
    end

    // Incremental update for the type change request -> reply
    ck_raw  = {1'b0, ~stored_checksum_next} + {1'b0, ~TC_ECHO_REQUEST} +
              {1'b0, TC_ECHO_REPLY};
    ck_fold = ck_raw[15:0] + {15'd0, ck_raw[16]};

    msg_bad = (byte_count_next < LENGTH_BITS'(min_header_bytes)) ||
              (type_code_word_next[7:0] != 8'h00) ||
              (running_sum_next != SUM_GOOD);

    cmd_data           = '0;
    cmd_data.op        = OP_REPORT;
    cmd_data.status    = ST_IGNORED;
    cmd_data.rec.src   = in_data.src_addr;
    cmd_data.rec.seq   = seq_field_next;
    cmd_data.rec.ticks = tick_field_next;
    unique case (in_data.mode)
      MODE_POP:   cmd_data.op = OP_POP;
      MODE_CLEAR: cmd_data.op = OP_CLEAR;
      MODE_NOP:   cmd_data.op = OP_REPORT;
      MODE_WORD: begin
        if (msg_bad) begin
          cmd_data.op = OP_REPORT;
        end else if (type_code_word_next == TC_ECHO_REQUEST) begin
          cmd_data.status   = ST_REPLY;
          cmd_data.checksum = ~ck_fold;
        end else if (type_code_word_next == TC_ECHO_REPLY &&
                     byte_count_next >= LENGTH_BITS'(REC_BYTES)) begin
          cmd_data.op = OP_PUSH;
        end
      end
      default: cmd_data.op = OP_REPORT;
    endcase
  end

  // Advance the message state; drop it after the final word
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum     <= '0;
      byte_count      <= '0;
      type_code_word  <= '0;
      stored_checksum <= '0;
      seq_field       <= '0;
      tick_field      <= '0;
    end else if (accept && msg_word) begin
      if (in_data.last_word) begin
        running_sum     <= '0;
        byte_count      <= '0;
        type_code_word  <= '0;
        stored_checksum <= '0;
        seq_field       <= '0;
        tick_field      <= '0;
      end else begin
        running_sum     <= running_sum_next;
        byte_count      <= byte_count_next;
        type_code_word  <= type_code_word_next;
        stored_checksum <= stored_checksum_next;
        seq_field       <= seq_field_next;
        tick_field      <= tick_field_next;
      end
    end
  end

endmodule

// ===== sv/iec_cmd_fifo.sv =====
`timescale 1ns / 1ps
// Short command queue between the front and back ends.
// Depends on iec_pkg for the command type and depth.
module iec_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  iec_pkg::cmd_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output iec_pkg::cmd_t rd_data
);
  import iec_pkg::*;

  localparam int AW = $clog2(CMD_FIFO_DEPTH);
  localparam int CW = $clog2(CMD_FIFO_DEPTH + 1);

  cmd_t          slots [CMD_FIFO_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign wr_ready = (count != CW'(CMD_FIFO_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(CMD_FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(CMD_FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

// ===== sv/iec_back.sv =====
`timescale 1ns / 1ps
// Back end: runs queue commands against the reply record memory and
// holds the result word in the output register. Depends on iec_pkg.
module iec_back #(
  parameter int QUEUE_DEPTH = iec_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  iec_pkg::cmd_t      cmd_data,
  output logic               out_valid,
  input  logic               out_ready,
  output iec_pkg::out_item_t out_data
);
  import iec_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int OW = $clog2(QUEUE_DEPTH + 1);

  rec_t          records [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [OW-1:0] occ;
  logic          full;
  logic          empty;
  logic          take;
  logic          do_push;
  logic          do_pop;
  out_item_t     out_data_next;

  assign cmd_ready = !out_valid || out_ready;
  assign take      = cmd_valid && cmd_ready;
  assign full      = (occ == OW'(QUEUE_DEPTH));
  assign empty     = (occ == '0);
  assign do_push   = take && (cmd_data.op == OP_PUSH) && !full;
  assign do_pop    = take && (cmd_data.op == OP_POP) && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      occ       <= '0;
    end else begin
      if (take) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (take && cmd_data.op == OP_CLEAR) begin
        wr_ptr <= '0;
        rd_ptr <= '0;
        occ    <= '0;
      end else if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
        occ    <= occ + 1'b1;
      end else if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
        occ    <= occ - 1'b1;
      end
    end
  end

  // Record memory: one write port, one combinational read port
  always_ff @(posedge clk) begin
    if (do_push) begin
      records[wr_ptr] <= cmd_data.rec;
    end
  end

  // Result word for the command at the queue head
  always_comb begin
    out_data_next = '0;
    unique case (cmd_data.op)
      OP_REPORT: begin
        out_data_next.status         = cmd_data.status;
        out_data_next.reply_checksum = cmd_data.checksum;
      end
      OP_PUSH:  out_data_next.status = full ? ST_FULL_DROP : ST_RECORDED;
      OP_POP: begin
        if (empty) begin
          out_data_next.status = ST_EMPTY;
        end else begin
          out_data_next.status    = ST_RECORD_OUT;
          out_data_next.rec_src   = records[rd_ptr].src;
          out_data_next.rec_seq   = records[rd_ptr].seq;
          out_data_next.rec_ticks = records[rd_ptr].ticks;
        end
      end
      OP_CLEAR: out_data_next.status = ST_CLEARED;
      default:  out_data_next.status = ST_IGNORED;
    endcase
  end

  // Output register; the record fields come straight from the memory read
  always_ff @(posedge clk) begin
    if (take) begin
      out_data <= out_data_next;
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= OW'(QUEUE_DEPTH))
    else $error("record queue occupancy beyond depth");

  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    (wr_ptr == rd_ptr) == (empty || full))
    else $error("queue pointers disagree with occupancy");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (take && cmd_data.op == OP_CLEAR) |=> empty)
    else $error("queue not empty after clear");

  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    (take && cmd_data.op == OP_POP && empty) |=>
      (out_valid && out_data.status == ST_EMPTY))
    else $error("pop from empty queue not reported as empty");

endmodule

// ===== sv/icmp_echo_checker.sv =====
`timescale 1ns / 1ps
// Top level of the ICMP echo checker: configuration register and the
// front end, command queue and back end. Depends on iec_pkg and all iec_ modules.
//
// The checker takes one 16-bit big-endian ICMP message word per clock and
// gives one result word for each final message word and for each pop, clear
// or no-op command; non-final message words give nothing. Throughput is one
// input word per cycle, sustained, as long as results are taken as fast.
// A result passes through the command queue and then the output
// register: the front end computes the ones-complement sum, length and
// verdict in the accepting cycle and writes a command into a two-entry
// queue, and the back end, once the output register is free, executes
// that command against the reply record memory and registers the result.
// Input ready drops only when that queue fills, i.e. when results back
// up behind a stalled output. Echo requests
// report the reply checksum (status 1); valid echo replies of twelve bytes
// or more store source address, sequence and timestamp words in a
// QUEUE_DEPTH-entry record memory, and a push into a full memory reports
// status 3 and drops the record. The record memory needs no clearing pass:
// reads only ever hit entries that were written. Write min_header_bytes
// (reset 8) only while no message result is outstanding.
module icmp_echo_checker #(
  parameter int QUEUE_DEPTH = iec_pkg::QUEUE_DEPTH_DEF,
  parameter int LENGTH_BITS = iec_pkg::LENGTH_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  iec_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output iec_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_data
);
  import iec_pkg::*;

  logic       [7:0] min_header_bytes;
  logic             front_valid;
  logic             front_ready;
  cmd_t             front_cmd;
  logic             back_valid;
  logic             back_ready;
  cmd_t             back_cmd;

  // Config writes are always taken
  assign cfg_ready = 1'b1;

  // Hold the minimum length; update on each config word
  always_ff @(posedge clk) begin
    if (rst) begin
      min_header_bytes <= MIN_HEADER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      min_header_bytes <= cfg_data;
    end
  end

  // Front end: message state and classification
  iec_front #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data          (in_data),
    .min_header_bytes (min_header_bytes),
    .cmd_valid        (front_valid),
    .cmd_ready        (front_ready),
    .cmd_data         (front_cmd)
  );

  // Decouple the two ends so each can stall on its own
  iec_cmd_fifo u_cmd_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .wr_data  (front_cmd),
    .rd_valid (back_valid),
    .rd_ready (back_ready),
    .rd_data  (back_cmd)
  );

  // Back end: record memory and output register
  iec_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (back_valid),
    .cmd_ready (back_ready),
    .cmd_data  (back_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== tb/icmp_echo_checker_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for icmp_echo_checker: message words and queue commands go in,
// each result word is predicted in-line and compared field by field.
// Depends on iec_pkg and the icmp_echo_checker RTL only.
module icmp_echo_checker_test;
  import iec_pkg::*;

  localparam int DEPTH         = QUEUE_DEPTH_DEF;
  localparam int CNT_WRAP      = 2 * DEPTH;
  localparam int LEN_CAP       = (1 << LENGTH_BITS_DEF) - 1;
  localparam int STALL_CYCLES  = 250;   // long output hold-off for the pressure test
  localparam int SETTLE_CYCLES = 6;     // pipeline is two deep; allow some slack
  localparam int DRAIN_LIMIT   = 20000;
  localparam int RANDOM_WORDS  = 1000;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [7:0] cfg_data = '0;

  // Mirror of the checker state: current message and reply record memory.
  logic [7:0]  min_len   = MIN_HEADER_RESET;
  logic [15:0] msg_sum   = '0;
  int          msg_len   = 0;
  logic [15:0] msg_tc    = '0;
  logic [15:0] msg_ck    = '0;
  logic [31:0] msg_seq   = '0;
  logic [31:0] msg_ticks = '0;
  rec_t        rec_mem [DEPTH];
  int          rec_wr    = 0;
  int          rec_rd    = 0;

  out_item_t   verdicts_due[$];   // result words owed by the checker, oldest first
  logic [15:0] msg_words[$];      // message under construction

  bit tx_idle_en   = 1'b1;
  bit rx_idle_en   = 1'b1;
  bit hold_request = 1'b0;
  int error_count  = 0;
  int words_sent   = 0;
  int cfg_writes   = 0;
  int status_seen [8];

  icmp_echo_checker i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Hard stop in case the checker wedges.
  initial begin : watchdog
    #(64'd20_000_000);
    $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure, plus one long hold-off on request.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    forever begin
      @(posedge clk);
      if (hold_request) begin
        // Hold ready low long enough for the command queue to fill and
        // in_ready to drop while the sender keeps offering words.
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
      end
      out_ready <= rx_idle_en ? ($urandom_range(99) >= 28) : 1'b1;
    end
  end

  task automatic report_mismatch(string what);
    error_count++;
    if (error_count <= 40) $display("%0t ns: mismatch: %s", $time, what);
  endtask

  // Compare every accepted result word with the oldest owed one.
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (verdicts_due.size() == 0) begin
        report_mismatch($sformatf("result with nothing owed, status %0d", out_data.status));
      end else begin
        want = verdicts_due.pop_front();
        status_seen[want.status]++;
        if (out_data.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", out_data.status, want.status));
        if (out_data.reply_checksum !== want.reply_checksum)
          report_mismatch($sformatf("reply_checksum %h, want %h",
                                    out_data.reply_checksum, want.reply_checksum));
        if (out_data.rec_src !== want.rec_src)
          report_mismatch($sformatf("rec_src %h, want %h", out_data.rec_src, want.rec_src));
        if (out_data.rec_seq !== want.rec_seq)
          report_mismatch($sformatf("rec_seq %h, want %h", out_data.rec_seq, want.rec_seq));
        if (out_data.rec_ticks !== want.rec_ticks)
          report_mismatch($sformatf("rec_ticks %h, want %h",
                                    out_data.rec_ticks, want.rec_ticks));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  function automatic logic [15:0] ones_add(logic [15:0] a, logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  function automatic void clear_msg();
    msg_sum   = '0;
    msg_len   = 0;
    msg_tc    = '0;
    msg_ck    = '0;
    msg_seq   = '0;
    msg_ticks = '0;
  endfunction

  // Advance the mirrored state by one accepted word; return 1 and the result
  // word when the word produces one.
  function automatic bit compute_verdict(input in_item_t it, output out_item_t res);
    logic [15:0] w;
    logic [31:0] c;
    int          step;
    int          fill;
    res  = '0;
    fill = (rec_wr + CNT_WRAP - rec_rd) % CNT_WRAP;
    case (it.mode)
      MODE_POP: begin
        if (fill == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.status    = ST_RECORD_OUT;
          res.rec_src   = rec_mem[rec_rd % DEPTH].src;
          res.rec_seq   = rec_mem[rec_rd % DEPTH].seq;
          res.rec_ticks = rec_mem[rec_rd % DEPTH].ticks;
          rec_rd        = (rec_rd + 1) % CNT_WRAP;
        end
        return 1'b1;
      end
      MODE_CLEAR: begin
        rec_wr     = 0;
        rec_rd     = 0;
        res.status = ST_CLEARED;
        return 1'b1;
      end
      MODE_NOP: begin
        res.status = ST_IGNORED;
        return 1'b1;
      end
      default: ;
    endcase

    // Message word: odd tail only counts on the final word.
    w    = it.data_word;
    step = 2;
    if (it.last_word && it.odd_tail) begin
      w[7:0] = 8'h00;
      step   = 1;
    end
    case (msg_len)
      OFS_TYPE_CODE: msg_tc = w;
      OFS_CHECKSUM:  msg_ck = w;
      OFS_SEQ_HI:    msg_seq[31:16] = w;
      OFS_SEQ_LO:    msg_seq[15:0] = w;
      OFS_TICKS_HI:  msg_ticks[31:16] = w;
      OFS_TICKS_LO:  msg_ticks[15:0] = w;
      default: ;
    endcase
    msg_sum = ones_add(msg_sum, w);
    msg_len = (msg_len + step > LEN_CAP) ? LEN_CAP : msg_len + step;
    if (!it.last_word) return 1'b0;

    res.status = ST_IGNORED;
    if (msg_len < min_len || msg_tc[7:0] != 8'h00 || msg_sum != SUM_GOOD) begin
      // short, nonzero code or bad checksum: drop
    end else if (msg_tc == TC_ECHO_REQUEST) begin
      // Incremental update: swap the request type/code for the reply one.
      c = {16'h0, msg_ck ^ 16'hffff} + {16'h0, TC_ECHO_REQUEST ^ 16'hffff}
          + {16'h0, TC_ECHO_REPLY};
      while (c[31:16] != 16'h0) c = {16'h0, c[31:16]} + {16'h0, c[15:0]};
      res.status         = ST_REPLY;
      res.reply_checksum = ~c[15:0];
    end else if (msg_tc == TC_ECHO_REPLY && msg_len >= REC_BYTES) begin
      if (fill >= DEPTH) begin
        res.status = ST_FULL_DROP;
      end else begin
        rec_mem[rec_wr % DEPTH] = '{src: it.src_addr, seq: msg_seq, ticks: msg_ticks};
        rec_wr     = (rec_wr + 1) % CNT_WRAP;
        res.status = ST_RECORDED;
      end
    end
    clear_msg();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic in_item_t rand_item();
    in_item_t it;
    it.mode      = 2'($urandom);
    it.data_word = 16'($urandom);
    it.odd_tail  = 1'($urandom);
    it.last_word = 1'($urandom);
    it.src_addr  = $urandom;
    return it;
  endfunction

  // Offer one word and hold it until accepted; then log what it owes.
  task automatic push_word(in_item_t it);
    out_item_t res;
    if (tx_idle_en && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 28);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    if (compute_verdict(it, res)) verdicts_due.push_back(res);
  endtask

  task automatic send_cmd(logic [1:0] mode);
    in_item_t it;
    it      = rand_item();
    it.mode = mode;
    push_word(it);
  endtask

  function automatic logic [1:0] pick_cmd();
    int r;
    r = $urandom_range(9);
    if (r < 6) return MODE_POP;
    if (r < 9) return MODE_NOP;
    return MODE_CLEAR;
  endfunction

  // Send msg_words as one message; the source address rides on the last word.
  task automatic send_built(bit odd, logic [31:0] src, bit interleave);
    in_item_t it;
    int       i;
    for (i = 0; i < msg_words.size(); i++) begin
      // Commands slipped in mid-message must leave the message intact.
      if (interleave && $urandom_range(99) < 8) send_cmd(pick_cmd());
      it           = rand_item();
      it.mode      = MODE_WORD;
      it.data_word = msg_words[i];
      it.last_word = (i == msg_words.size() - 1);
      if (it.last_word) begin
        it.odd_tail = odd;
        it.src_addr = src;
      end
      push_word(it);
    end
  endtask

  // Build a message of nbytes with a correct checksum, then maybe flip one bit.
  task automatic send_msg(logic [15:0] tc, int nbytes, bit spoil, bit interleave);
    logic [15:0] s;
    logic [15:0] v;
    int          n;
    int          i;
    int          j;
    bit          odd;
    n   = (nbytes + 1) / 2;
    odd = nbytes[0];
    msg_words = {};
    msg_words.push_back(tc);
    for (i = 1; i < n; i++) msg_words.push_back(16'($urandom));
    // Fix the checksum word unless it is itself a masked odd tail.
    if (n > 2 || (n == 2 && !odd)) begin
      s = '0;
      for (i = 0; i < n; i++) begin
        if (i != 1) begin
          v = msg_words[i];
          if (odd && i == n - 1) v[7:0] = 8'h00;
          s = ones_add(s, v);
        end
      end
      msg_words[1] = ~s;
    end
    if (spoil) begin
      j = $urandom_range(n - 1);
      msg_words[j] = msg_words[j] ^ (16'h1 << $urandom_range(15));
    end
    send_built(odd, $urandom, interleave);
  endtask

  // Drop valid and wait until every owed result is out, then let the pipe settle.
  task automatic drain_verdicts();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    while (verdicts_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_min_len(logic [7:0] v);
    drain_verdicts();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    min_len = v;
    cfg_writes++;
  endtask

  function automatic logic [15:0] pick_tc();
    int r;
    r = $urandom_range(99);
    if (r < 40) return TC_ECHO_REQUEST;
    if (r < 80) return TC_ECHO_REPLY;
    if (r < 90) return {8'($urandom), 8'h00};
    return 16'($urandom);
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 3) return $urandom_range(250, 260);
    if (r < 15) return $urandom_range(1, 7);
    return $urandom_range(8, 24);
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    int i;
    send_msg(TC_ECHO_REQUEST, 8, 1'b0, 1'b0);    // plain echo request
    send_msg(TC_ECHO_REQUEST, 9, 1'b0, 1'b0);    // request with odd tail
    // Reply with all-ones sequence and timestamp, all-ones source.
    msg_words = {16'h0000, 16'h0000, 16'hffff, 16'hffff, 16'hffff, 16'hffff};
    send_built(1'b0, 32'hffff_ffff, 1'b0);
    // Reply with all-zero fields and source.
    msg_words = {16'h0000, 16'hffff, 16'h0000, 16'h0000, 16'h0000, 16'h0000};
    send_built(1'b0, 32'h0000_0000, 1'b0);
    send_msg(TC_ECHO_REPLY, 13, 1'b0, 1'b0);     // reply with odd tail
    send_msg(TC_ECHO_REPLY, 10, 1'b0, 1'b0);     // reply too short to record
    send_msg(16'h0d00, 8, 1'b0, 1'b0);           // unknown type
    send_msg(16'h0801, 8, 1'b0, 1'b0);           // nonzero code
    send_msg(TC_ECHO_REQUEST, 8, 1'b1, 1'b0);    // broken checksum
    send_msg(TC_ECHO_REQUEST, 6, 1'b0, 1'b0);    // under the minimum length
    send_msg(TC_ECHO_REPLY, 12, 1'b0, 1'b1);     // commands interleaved
    for (i = 0; i < 5; i++) send_cmd(MODE_POP);  // drain records, then empty
    send_cmd(MODE_NOP);
    send_cmd(MODE_CLEAR);
    send_cmd(MODE_POP);
  endtask

  task automatic test_record_queue();
    int i;
    send_cmd(MODE_CLEAR);
    // One more reply than the memory holds: the last is dropped.
    for (i = 0; i <= DEPTH; i++) send_msg(TC_ECHO_REPLY, 12 + 2 * $urandom_range(4), 1'b0, 1'b0);
    for (i = 0; i < 3; i++) send_cmd(MODE_POP);
    // Refill across the wrap of the write index.
    for (i = 0; i < 4; i++) send_msg(TC_ECHO_REPLY, 12, 1'b0, 1'b0);
    for (i = 0; i <= DEPTH; i++) send_cmd(MODE_POP);
    // Clear with records pending.
    send_msg(TC_ECHO_REPLY, 16, 1'b0, 1'b0);
    send_msg(TC_ECHO_REPLY, 12, 1'b0, 1'b0);
    send_cmd(MODE_CLEAR);
    send_cmd(MODE_POP);
  endtask

  task automatic test_min_length();
    write_min_len(8'd0);
    send_msg(TC_ECHO_REQUEST, 1, 1'b0, 1'b0);
    send_msg(TC_ECHO_REQUEST, 4, 1'b0, 1'b0);
    send_msg(TC_ECHO_REPLY, 12, 1'b0, 1'b0);
    write_min_len(8'd255);
    send_msg(TC_ECHO_REPLY, 254, 1'b0, 1'b0);
    send_msg(TC_ECHO_REPLY, 255, 1'b0, 1'b0);
    send_msg(TC_ECHO_REQUEST, 256, 1'b0, 1'b0);
    write_min_len(8'd12);
    send_msg(TC_ECHO_REQUEST, 11, 1'b0, 1'b0);
    send_msg(TC_ECHO_REQUEST, 12, 1'b0, 1'b0);
    write_min_len(MIN_HEADER_RESET);
    send_cmd(MODE_CLEAR);
  endtask

  // Keep offering result-producing words while the result side is held off.
  task automatic test_output_stall();
    int i;
    tx_idle_en   = 1'b0;
    hold_request = 1'b1;
    for (i = 0; i < 48; i++) begin
      if (i % 4 == 3) send_msg(TC_ECHO_REQUEST, 8, 1'b0, 1'b0);
      else send_cmd((i % 3 == 0) ? MODE_NOP : MODE_POP);
    end
    tx_idle_en = 1'b1;
  endtask

  task automatic test_random_traffic();
    logic [7:0] limits [6];
    int         phase;
    int         stop_at;
    int         r;
    limits    = '{8'd8, 8'd0, 8'd12, 8'd0, 8'd255, MIN_HEADER_RESET};
    limits[3] = 8'($urandom_range(1, 254));
    for (phase = 0; phase < 6; phase++) begin
      write_min_len(limits[phase]);
      // Phase 2 runs flat out on both sides.
      tx_idle_en = (phase != 2);
      rx_idle_en = (phase != 2);
      stop_at = words_sent + ((phase == 4) ? RANDOM_WORDS / 10 : RANDOM_WORDS * 9 / 50);
      while (words_sent < stop_at) begin
        r = $urandom_range(99);
        if (r < 72) send_msg(pick_tc(), pick_len(), $urandom_range(99) < 8, 1'b1);
        else if (r < 86) send_cmd(MODE_POP);
        else if (r < 89) send_cmd(MODE_CLEAR);
        else if (r < 91) send_cmd(MODE_NOP);
        else repeat ($urandom_range(1, 4)) push_word(rand_item());   // ragged noise
      end
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin : run_tests
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_record_queue();
    test_min_length();
    test_output_stall();
    test_random_traffic();
    drain_verdicts();
    if (verdicts_due.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", verdicts_due.size()));
    $display("Covered %0d words, %0d length settings: %0d reply checksums, %0d records, %0d drops",
             words_sent, cfg_writes, status_seen[ST_REPLY], status_seen[ST_RECORDED],
             status_seen[ST_FULL_DROP]);
    $display("Popped %0d records, %0d empty pops, %0d clears, %0d ignored; %0d mismatches",
             status_seen[ST_RECORD_OUT], status_seen[ST_EMPTY], status_seen[ST_CLEARED],
             status_seen[ST_IGNORED], error_count);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
